// ===== rtl/ssm_pkg.sv =====
// Shared types and constants for the servo smoothing mapper.
// Holds the configuration struct, operation and register codes, and the
// classified item that travels from the front end to the back end.
package ssm_pkg;

  // Field widths fixed by the interface.
  localparam int STATE_W    = 20;
  localparam int SAMPLE_W   = 10;
  localparam int PULSE_W    = 12;
  localparam int BYTE_W     = 8;
  localparam int WEIGHT_W   = 8;
  localparam int CH_W       = 4;
  localparam int EN_W       = 16;
  localparam int OP_W       = 2;
  localparam int DEN_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Operation codes of an input item.
  localparam logic [OP_W-1:0] OP_LIVE   = 2'd0;
  localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
  localparam logic [OP_W-1:0] OP_PLAY   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0] RST_INPUT_LOW  = 10'd0;
  localparam logic [SAMPLE_W-1:0] RST_INPUT_HIGH = 10'd1023;
  localparam logic [PULSE_W-1:0]  RST_PULSE_LOW  = 12'd150;
  localparam logic [PULSE_W-1:0]  RST_PULSE_HIGH = 12'd600;

  // Saturation limits.
  localparam logic [PULSE_W-1:0] PULSE_MAX = 12'd4095;
  localparam logic [BYTE_W-1:0]  BYTE_MAX  = 8'd255;

  typedef struct packed {
    logic [SAMPLE_W-1:0] input_low;
    logic [SAMPLE_W-1:0] input_high;
    logic [PULSE_W-1:0]  pulse_low;
    logic [PULSE_W-1:0]  pulse_high;
    logic                invert_dir;
    logic [WEIGHT_W-1:0] smooth_weight;
    logic [EN_W-1:0]     channel_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_LIVE,
    KIND_RECORD,
    KIND_PLAY
  } kind_t;

  // A classified item. When pos_ready is set, value already holds the
  // position byte; otherwise it holds the clamped reading minus input_low.
  typedef struct packed {
    kind_t               kind;
    logic [CH_W-1:0]     channel;
    logic                pos_ready;
    logic [SAMPLE_W-1:0] value;
  } item_t;

endpackage

// ===== rtl/ssm_div.sv =====
// Iterative unsigned divider, two quotient bits per cycle.
// Used by the back end for every map and smoothing division; needs no package.
module ssm_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEPS = NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  // Two restoring steps: shift in the next numerator bit, subtract if it fits.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_nxt = {rem_nxt[DEN_W-1:0], quo_nxt[NUM_W-1]};
      quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
      if (rem_nxt >= {1'b0, den_r}) begin
        rem_nxt    = rem_nxt - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
    end
  end

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient register doubles as the numerator shifter.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/ssm_front.sv =====
// Front end of the servo smoothing mapper: accepts input items, drops the
// ignored ones, clamps and classifies the rest into a two-entry queue.
// Depends on ssm_pkg.
module ssm_front #(
  parameter int CHANNELS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssm_pkg::cfg_t                cfg,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [ssm_pkg::OP_W-1:0]     in_operation,
  input  logic [ssm_pkg::CH_W-1:0]     in_channel,
  input  logic [ssm_pkg::SAMPLE_W-1:0] in_sample,
  output ssm_pkg::item_t               q_item,
  output logic                         q_valid,
  input  logic                         q_pop
);

  logic                         keep;
  logic                         q_push;
  logic [ssm_pkg::SAMPLE_W-1:0] xc;
  ssm_pkg::item_t               item_nxt;
  ssm_pkg::item_t               ent_r [2];
  logic                         wptr_r;
  logic                         rptr_r;
  logic [1:0]                   cnt_r;
  logic [1:0]                   cnt_nxt;

  // Unused operation, out-of-range or disabled channel: no result at all.
  assign keep = (in_operation != ssm_pkg::OP_UNUSED) &&
                (32'(in_channel) < CHANNELS) &&
                cfg.channel_enable[in_channel];

  // Clamp tests the lower bound first, then the upper bound.
  always_comb begin
    if (in_sample < cfg.input_low) begin
      xc = cfg.input_low;
    end else if (in_sample > cfg.input_high) begin
      xc = cfg.input_high;
    end else begin
      xc = in_sample;
    end
  end

  // Classify: settle the position here when no division is needed.
  always_comb begin
    item_nxt.channel   = in_channel;
    item_nxt.pos_ready = 1'b1;
    item_nxt.value     = '0;
    case (in_operation)
      ssm_pkg::OP_LIVE:   item_nxt.kind = ssm_pkg::KIND_LIVE;
      ssm_pkg::OP_RECORD: item_nxt.kind = ssm_pkg::KIND_RECORD;
      default:            item_nxt.kind = ssm_pkg::KIND_PLAY;
    endcase
    if (in_operation == ssm_pkg::OP_PLAY) begin
      // A stored byte above 255 saturates.
      if (in_sample > ssm_pkg::SAMPLE_W'(ssm_pkg::BYTE_MAX)) begin
        item_nxt.value = ssm_pkg::SAMPLE_W'(ssm_pkg::BYTE_MAX);
      end else begin
        item_nxt.value = in_sample;
      end
    end else if (cfg.input_low == cfg.input_high) begin
      // Equal bounds map to position zero.
      item_nxt.value = '0;
    end else if (cfg.input_low > cfg.input_high) begin
      // Reversed bounds: clamped to the lower bound gives 0, else 255.
      if (in_sample < cfg.input_low) begin
        item_nxt.value = '0;
      end else begin
        item_nxt.value = ssm_pkg::SAMPLE_W'(ssm_pkg::BYTE_MAX);
      end
    end else begin
      item_nxt.pos_ready = 1'b0;
      item_nxt.value     = xc - cfg.input_low;
    end
  end

  assign q_push  = in_push && !in_full && keep;
  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!q_push && q_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (q_push) begin
        wptr_r <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Queue entries.
  always_ff @(posedge clk) begin
    if (q_push) begin
      ent_r[wptr_r] <= item_nxt;
    end
  end

endmodule

// ===== rtl/ssm_back.sv =====
// Back end of the servo smoothing mapper: a sequencer that runs the position
// map, pulse map and smoothing divisions on one shared divider, keeps the
// per-channel smoothed values and holds the result register.
// Depends on ssm_pkg and ssm_div.
module ssm_back #(
  parameter int CHANNELS  = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ssm_pkg::cfg_t               cfg,
  input  ssm_pkg::item_t              q_item,
  input  logic                        q_valid,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ssm_pkg::CH_W-1:0]    out_channel,
  output logic [ssm_pkg::PULSE_W-1:0] out_pulse_width,
  output logic [ssm_pkg::BYTE_W-1:0]  out_recorded_byte,
  output logic                        out_record_valid
);

  localparam int SW     = ssm_pkg::STATE_W;
  localparam int PW     = ssm_pkg::PULSE_W;
  localparam int BW     = ssm_pkg::BYTE_W;
  localparam int WW     = ssm_pkg::WEIGHT_W;
  localparam int DW     = ssm_pkg::DEN_W;
  localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PX_W   = (SW - FRAC_BITS > BW) ? SW - FRAC_BITS : BW;
  localparam int MAP_W  = PX_W + PW;
  localparam int FIX_W  = PW + FRAC_BITS;
  localparam int PROD_W = SW + WW;
  localparam int SM_W   = ((FIX_W > PROD_W) ? FIX_W : PROD_W) + 1;
  localparam int BY_W   = ssm_pkg::SAMPLE_W + BW;
  localparam int MX_W   = (MAP_W > SM_W) ? MAP_W : SM_W;
  localparam int RAW_W  = (MX_W > BY_W) ? MX_W : BY_W;
  localparam int DIV_W  = RAW_W + (RAW_W % 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POS,
    ST_POS_WAIT,
    ST_PL_GO,
    ST_PL_WAIT,
    ST_SM_GO,
    ST_SM_WAIT,
    ST_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  ssm_pkg::kind_t                kind_r, kind_nxt;
  logic [ssm_pkg::CH_W-1:0]      ch_r, ch_nxt;
  logic                          pos_ready_r, pos_ready_nxt;
  logic [ssm_pkg::SAMPLE_W-1:0]  val_r, val_nxt;
  logic [BW-1:0]                 pos_r, pos_nxt;
  logic [BW-1:0]                 byte_r, byte_nxt;
  logic [PW-1:0]                 pulse_r, pulse_nxt;
  logic [PX_W-1:0]               plx_r, plx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ssm_pkg::CH_W-1:0]      out_ch_r, out_ch_nxt;
  logic [PW-1:0]                 out_pulse_r, out_pulse_nxt;
  logic [BW-1:0]                 out_byte_r, out_byte_nxt;
  logic                          out_rec_r, out_rec_nxt;

  logic [SW-1:0]                 sm_mem [CHANNELS];
  logic [SW-1:0]                 rd_r;
  logic [CHANNELS-1:0]           vld_r;
  logic                          mem_we;
  logic [CH_IW-1:0]              ch_idx;

  logic                          div_start;
  logic [DIV_W-1:0]              div_num;
  logic [DW-1:0]                 div_den;
  logic                          div_done;
  logic [DIV_W-1:0]              div_q;

  logic [PW-1:0]                 plo;
  logic [PW-1:0]                 phi;
  logic                          pneg;
  logic [PW-1:0]                 pmag;
  logic [PW-1:0]                 pl_val;
  logic [DIV_W:0]                pl_sum;
  logic [SW-1:0]                 old_v;
  logic [SW-1:0]                 sm_new;
  logic [SW-1:0]                 sm_int;
  logic [PW-1:0]                 sm_pulse;
  logic [BW-1:0]                 div_byte;
  logic [PW-1:0]                 fix_src;
  logic [FIX_W-1:0]              fix_v;

  ssm_div #(
    .NUM_W (DIV_W),
    .DEN_W (DW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign ch_idx = CH_IW'(ch_r);

  // Pulse range endpoints, swapped when inverted, and the signed span.
  assign plo  = cfg.invert_dir ? cfg.pulse_high : cfg.pulse_low;
  assign phi  = cfg.invert_dir ? cfg.pulse_low : cfg.pulse_high;
  assign pneg = (phi < plo);
  assign pmag = pneg ? (plo - phi) : (phi - plo);

  // Pulse map result: endpoint plus or minus the quotient, saturated.
  assign pl_sum = (DIV_W + 1)'(plo) + {1'b0, div_q};
  always_comb begin
    if (pneg) begin
      if (div_q > DIV_W'(plo)) begin
        pl_val = '0;
      end else begin
        pl_val = plo - PW'(div_q);
      end
    end else if (pl_sum > (DIV_W + 1)'(ssm_pkg::PULSE_MAX)) begin
      pl_val = ssm_pkg::PULSE_MAX;
    end else begin
      pl_val = PW'(pl_sum);
    end
  end

  // Smoothing operands and result.
  assign old_v    = vld_r[ch_idx] ? rd_r : '0;
  assign fix_src  = (kind_r == ssm_pkg::KIND_LIVE) ? PW'(pos_r) : pulse_r;
  assign fix_v    = FIX_W'(fix_src) << FRAC_BITS;
  assign sm_new   = div_q[SW-1:0];
  assign sm_int   = sm_new >> FRAC_BITS;
  assign sm_pulse = (sm_int > SW'(ssm_pkg::PULSE_MAX)) ? ssm_pkg::PULSE_MAX : PW'(sm_int);
  assign div_byte = BW'(div_q);

  // Divider operands per sequencer step.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      ST_POS: begin
        if (!pos_ready_r) begin
          div_start = 1'b1;
          div_num   = DIV_W'((BY_W'(val_r) << BW) - BY_W'(val_r));
          div_den   = DW'(cfg.input_high - cfg.input_low);
        end
      end
      ST_PL_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(MAP_W'(plx_r) * MAP_W'(pmag));
        div_den   = DW'(ssm_pkg::BYTE_MAX);
      end
      ST_SM_GO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(fix_v) +
                    DIV_W'(PROD_W'(old_v) * PROD_W'(cfg.smooth_weight));
        div_den   = DW'(cfg.smooth_weight) + DW'(1);
      end
      default: begin
      end
    endcase
  end

  // Sequencer next-state and datapath register updates.
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    ch_nxt        = ch_r;
    pos_ready_nxt = pos_ready_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    byte_nxt      = byte_r;
    pulse_nxt     = pulse_r;
    plx_nxt       = plx_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_ch_nxt    = out_ch_r;
    out_pulse_nxt = out_pulse_r;
    out_byte_nxt  = out_byte_r;
    out_rec_nxt   = out_rec_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          kind_nxt      = q_item.kind;
          ch_nxt        = q_item.channel;
          pos_ready_nxt = q_item.pos_ready;
          val_nxt       = q_item.value;
          byte_nxt      = '0;
          state_nxt     = ST_POS;
        end
      end
      ST_POS: begin
        if (pos_ready_r) begin
          pos_nxt = BW'(val_r);
          plx_nxt = PX_W'(BW'(val_r));
          if (kind_r == ssm_pkg::KIND_RECORD) begin
            byte_nxt = BW'(val_r);
          end
          state_nxt = (kind_r == ssm_pkg::KIND_LIVE) ? ST_SM_GO : ST_PL_GO;
        end else begin
          state_nxt = ST_POS_WAIT;
        end
      end
      ST_POS_WAIT: begin
        if (div_done) begin
          pos_nxt = div_byte;
          plx_nxt = PX_W'(div_byte);
          if (kind_r == ssm_pkg::KIND_RECORD) begin
            byte_nxt = div_byte;
          end
          state_nxt = (kind_r == ssm_pkg::KIND_LIVE) ? ST_SM_GO : ST_PL_GO;
        end
      end
      ST_PL_GO: begin
        state_nxt = ST_PL_WAIT;
      end
      ST_PL_WAIT: begin
        if (div_done) begin
          pulse_nxt = pl_val;
          state_nxt = (kind_r == ssm_pkg::KIND_LIVE) ? ST_DONE : ST_SM_GO;
        end
      end
      ST_SM_GO: begin
        state_nxt = ST_SM_WAIT;
      end
      ST_SM_WAIT: begin
        if (div_done) begin
          mem_we = 1'b1;
          if (kind_r == ssm_pkg::KIND_LIVE) begin
            // Live mode maps the integer part of the smoothed position.
            plx_nxt   = PX_W'(sm_int);
            state_nxt = ST_PL_GO;
          end else begin
            pulse_nxt = sm_pulse;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = ch_r;
          out_pulse_nxt = pulse_r;
          out_byte_nxt  = byte_r;
          out_rec_nxt   = (kind_r == ssm_pkg::KIND_RECORD);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, working registers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        vld_r[ch_idx] <= 1'b1;
      end
    end
    kind_r      <= kind_nxt;
    ch_r        <= ch_nxt;
    pos_ready_r <= pos_ready_nxt;
    val_r       <= val_nxt;
    pos_r       <= pos_nxt;
    byte_r      <= byte_nxt;
    pulse_r     <= pulse_nxt;
    plx_r       <= plx_nxt;
    out_ch_r    <= out_ch_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_byte_r  <= out_byte_nxt;
    out_rec_r   <= out_rec_nxt;
  end

  // Smoothed-value memory; read when an item is taken from the queue.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_r <= sm_mem[CH_IW'(q_item.channel)];
    end
    if (mem_we) begin
      sm_mem[ch_idx] <= sm_new;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_channel       = out_ch_r;
  assign out_pulse_width   = out_pulse_r;
  assign out_recorded_byte = out_byte_r;
  assign out_record_valid  = out_rec_r;

endmodule

// ===== rtl/servo_smoothing_mapper.sv =====
// Servo smoothing mapper top level: configuration registers, front end, back end.
// Live and record items run three divisions (position map, pulse map, smoothing) on the
// shared divider of width D (30 at the default FRAC_BITS); play items and equal or reversed
// input bounds skip the position division. The back end takes a new item only after the
// last result is in the result register; dropped items never enter the queue.
// Reset clears the input queue, result register and per-channel valid bits; configuration defaults.
module servo_smoothing_mapper #(
  parameter int CHANNELS  = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [ssm_pkg::OP_W-1:0]       in_operation,
  input  logic [ssm_pkg::CH_W-1:0]       in_channel,
  input  logic [ssm_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [ssm_pkg::CH_W-1:0]       out_channel,
  output logic [ssm_pkg::PULSE_W-1:0]    out_pulse_width,
  output logic [ssm_pkg::BYTE_W-1:0]     out_recorded_byte,
  output logic                           out_record_valid,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssm_pkg::CFG_DATA_W-1:0] cfg_data
);

  ssm_pkg::cfg_t  cfg_r;
  ssm_pkg::item_t q_item;
  logic           q_valid;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_low      <= ssm_pkg::RST_INPUT_LOW;
      cfg_r.input_high     <= ssm_pkg::RST_INPUT_HIGH;
      cfg_r.pulse_low      <= ssm_pkg::RST_PULSE_LOW;
      cfg_r.pulse_high     <= ssm_pkg::RST_PULSE_HIGH;
      cfg_r.invert_dir     <= 1'b0;
      cfg_r.smooth_weight  <= '0;
      cfg_r.channel_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssm_pkg::REG_INPUT_LOW:      cfg_r.input_low <= cfg_data[ssm_pkg::SAMPLE_W-1:0];
        ssm_pkg::REG_INPUT_HIGH:     cfg_r.input_high <= cfg_data[ssm_pkg::SAMPLE_W-1:0];
        ssm_pkg::REG_PULSE_LOW:      cfg_r.pulse_low <= cfg_data[ssm_pkg::PULSE_W-1:0];
        ssm_pkg::REG_PULSE_HIGH:     cfg_r.pulse_high <= cfg_data[ssm_pkg::PULSE_W-1:0];
        ssm_pkg::REG_INVERT_DIR:     cfg_r.invert_dir <= cfg_data[0];
        ssm_pkg::REG_SMOOTH_WEIGHT:  cfg_r.smooth_weight <= cfg_data[ssm_pkg::WEIGHT_W-1:0];
        ssm_pkg::REG_CHANNEL_ENABLE: cfg_r.channel_enable <= cfg_data[ssm_pkg::EN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssm_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_operation (in_operation),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  ssm_back #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_item            (q_item),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_channel       (out_channel),
    .out_pulse_width   (out_pulse_width),
    .out_recorded_byte (out_recorded_byte),
    .out_record_valid  (out_record_valid)
  );

  // A waiting result that is not from record mode carries no position byte.
  a_byte_only_on_record: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_record_valid) |-> (out_recorded_byte == '0))
    else $error("recorded byte set on a result outside record mode");

  // Every result belongs to an enabled channel in range.
  a_result_channel_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (cfg_r.channel_enable[out_channel] && (32'(out_channel) < CHANNELS)))
    else $error("result produced for a disabled or out-of-range channel");

  // An item with the unused operation never takes a queue slot.
  a_dropped_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && (in_operation == ssm_pkg::OP_UNUSED)) |=> !$rose(in_full))
    else $error("ignored item filled the input queue");

endmodule

// ===== dv/servo_smoothing_mapper_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for servo_smoothing_mapper: a directed table, then random settings phases.
// Depends on ssm_pkg for port widths, operation codes, register indexes and reset values.
module tb;
  import ssm_pkg::*;

  localparam int CHANNELS        = 16;
  localparam int FRAC_BITS       = 8;
  localparam int RESET_CYCLES    = 11;
  localparam int SETTLE_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int DIRECTED_ROWS   = 30;

  // Index 7 is decoded by nobody; writes to it must leave the settings alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] sample;
  } servo_cmd_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [PULSE_W-1:0] pulse;
    logic [BYTE_W-1:0]  rec_byte;
    logic               rec_valid;
  } pulse_update_t;

  // One row of the directed table: either a register write or a command.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    servo_cmd_t            cmd;
    logic                  pinned;
    pulse_update_t         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OP_W-1:0] in_operation = '0;
  logic [CH_W-1:0] in_channel = '0;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [CH_W-1:0] out_channel;
  logic [PULSE_W-1:0] out_pulse_width;
  logic [BYTE_W-1:0] out_recorded_byte;
  logic out_record_valid;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Expected result typed into the table travels with the command it belongs to.
  logic pinned_on = 1'b0;
  pulse_update_t pinned_update = '0;

  // Predictor state: settings as written and one smoothed position per channel.
  cfg_t tracked_cfg;
  logic [STATE_W-1:0] smoothed_pos [CHANNELS];
  pulse_update_t pending_updates [$];

  logic idle_on = 1'b1;
  logic [CH_W-1:0] last_channel = '0;
  int pop_hold = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int items_sent = 0;
  int items_ignored = 0;
  int updates_checked = 0;
  int records_checked = 0;
  int reg_writes = 0;

  plan_row_t directed_plan [DIRECTED_ROWS];

  servo_smoothing_mapper #(
    .CHANNELS(CHANNELS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_operation(in_operation),
    .in_channel(in_channel),
    .in_sample(in_sample),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_channel(out_channel),
    .out_pulse_width(out_pulse_width),
    .out_recorded_byte(out_recorded_byte),
    .out_record_valid(out_record_valid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Integer linear map; a zero-width source range maps to zero.
  function automatic longint linear_map(input longint x, a, b, c, d);
    if (a == b) return 0;
    return (x - a) * (d - c) / (b - a) + c;
  endfunction

  function automatic longint saturate(input longint v, lo, hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Clamp a raw reading to the input bounds (lower bound tested first) and map it to a byte.
  function automatic longint reading_to_position(input logic [SAMPLE_W-1:0] raw);
    longint x, lo, hi;
    x = longint'(raw);
    lo = longint'(tracked_cfg.input_low);
    hi = longint'(tracked_cfg.input_high);
    if (x < lo) x = lo;
    else if (x > hi) x = hi;
    return saturate(linear_map(x, lo, hi, 0, longint'(BYTE_MAX)), 0, longint'(BYTE_MAX));
  endfunction

  // Map a position to the pulse range, swapped ends when inverted, then saturate.
  function automatic longint position_to_pulse(input longint pos);
    longint lo, hi;
    lo = longint'(tracked_cfg.invert_dir ? tracked_cfg.pulse_high : tracked_cfg.pulse_low);
    hi = longint'(tracked_cfg.invert_dir ? tracked_cfg.pulse_low : tracked_cfg.pulse_high);
    return saturate(linear_map(pos, 0, longint'(BYTE_MAX), lo, hi), 0, longint'(PULSE_MAX));
  endfunction

  // Weighted average of the fresh fixed-point value and the old state, truncated.
  function automatic logic [STATE_W-1:0] blend_smoothed(input logic [STATE_W-1:0] old,
                                                       input longint fresh);
    longint w;
    w = longint'(tracked_cfg.smooth_weight);
    return STATE_W'((fresh + longint'(old) * w) / (w + 1));
  endfunction

  // Advance the channel state for one command; returns 0 when the command is dropped.
  function automatic logic predict_pulse_update(input servo_cmd_t c, output pulse_update_t r);
    longint pos, pulse;
    r = '0;
    r.ch = c.ch;
    if (c.op == OP_UNUSED || int'(c.ch) >= CHANNELS || !tracked_cfg.channel_enable[c.ch])
      return 1'b0;
    if (c.op == OP_LIVE) begin
      pos = reading_to_position(c.sample);
      smoothed_pos[c.ch] = blend_smoothed(smoothed_pos[c.ch], pos << FRAC_BITS);
      pulse = position_to_pulse(longint'(smoothed_pos[c.ch] >> FRAC_BITS));
    end else begin
      if (c.op == OP_RECORD) begin
        pos = reading_to_position(c.sample);
        r.rec_byte = BYTE_W'(pos);
        r.rec_valid = 1'b1;
      end else begin
        pos = (c.sample > SAMPLE_W'(BYTE_MAX)) ? longint'(BYTE_MAX) : longint'(c.sample);
      end
      pulse = position_to_pulse(pos);
      smoothed_pos[c.ch] = blend_smoothed(smoothed_pos[c.ch], pulse << FRAC_BITS);
      pulse = saturate(longint'(smoothed_pos[c.ch] >> FRAC_BITS), 0, longint'(PULSE_MAX));
    end
    r.pulse = PULSE_W'(pulse);
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Mostly short gaps, now and then a long one; none while idling is off.
  function automatic int gap_length();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Random bits above the register width so every data bit toggles.
  function automatic logic [CFG_DATA_W-1:0] pad_upper(input logic [CFG_DATA_W-1:0] v,
                                                      input int width);
    logic [CFG_DATA_W-1:0] keep_mask;
    keep_mask = CFG_DATA_W'((32'd1 << width) - 1);
    return (v & keep_mask) | (CFG_DATA_W'($urandom) & ~keep_mask);
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t cmd_row(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                        input logic [SAMPLE_W-1:0] smp);
    plan_row_t row;
    row = '0;
    row.cmd = '{op: op, ch: ch, sample: smp};
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                          input logic [SAMPLE_W-1:0] smp,
                                          input logic [PULSE_W-1:0] pulse,
                                          input logic [BYTE_W-1:0] rbyte, input logic rvalid);
    plan_row_t row;
    row = cmd_row(op, ch, smp);
    row.pinned = 1'b1;
    row.want = '{ch: ch, pulse: pulse, rec_byte: rbyte, rec_valid: rvalid};
    return row;
  endfunction

  // Random command; channels repeat in runs so smoothing has time to settle.
  function automatic servo_cmd_t random_command();
    servo_cmd_t c;
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) c.op = OP_UNUSED;
    else if (r <= 8) c.op = OP_LIVE;
    else if (r <= 14) c.op = OP_RECORD;
    else c.op = OP_PLAY;
    if ($urandom_range(0, 9) < 6) c.ch = last_channel;
    else c.ch = CH_W'($urandom_range(0, 15));
    last_channel = c.ch;
    if (c.op == OP_PLAY) begin
      if ($urandom_range(0, 6) == 0) c.sample = SAMPLE_W'($urandom_range(256, 1023));
      else c.sample = SAMPLE_W'($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 9))
        0: c.sample = '0;
        1: c.sample = '1;
        2: c.sample = tracked_cfg.input_low;
        3: c.sample = tracked_cfg.input_high;
        default: c.sample = SAMPLE_W'($urandom_range(0, 1023));
      endcase
    end
    return c;
  endfunction

  // Push one command after an optional gap; returns at the edge that takes it.
  task automatic send_command(input servo_cmd_t c, input logic pinned,
                              input pulse_update_t want);
    int gap;
    gap = gap_length();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if ($urandom_range(0, 47) == 0) idle_on <= !idle_on;
    in_push <= 1'b1;
    in_operation <= c.op;
    in_channel <= c.ch;
    in_sample <= c.sample;
    pinned_on <= pinned;
    pinned_update <= want;
    do @(posedge clk); while (in_full !== 1'b0);
  endtask

  // Register write; valid stays high when another write follows at once.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data, input logic keep);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (!keep) cfg_valid <= 1'b0;
  endtask

  // Stop pushing, let every expected result drain, then allow dropped items to clear.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Settings for one random phase; the first two are the extremes.
  task automatic program_phase(input int phase);
    logic [SAMPLE_W-1:0] lo_in, hi_in;
    logic [PULSE_W-1:0] lo_p, hi_p;
    logic inv;
    logic [WEIGHT_W-1:0] w;
    logic [EN_W-1:0] en;
    if (phase == 0) begin
      lo_in = '1; hi_in = '1; lo_p = '1; hi_p = '1; inv = 1'b1; w = '1; en = '1;
    end else if (phase == 1) begin
      lo_in = '0; hi_in = '0; lo_p = '0; hi_p = '0; inv = 1'b0; w = '0; en = '1;
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          lo_in = SAMPLE_W'($urandom_range(0, 1023));
          hi_in = lo_in;
        end
        1: begin
          lo_in = SAMPLE_W'($urandom_range(512, 1023));
          hi_in = SAMPLE_W'($urandom_range(0, 511));
        end
        2: begin
          lo_in = '0;
          hi_in = '1;
        end
        default: begin
          lo_in = SAMPLE_W'($urandom_range(0, 400));
          hi_in = SAMPLE_W'($urandom_range(600, 1023));
        end
      endcase
      case ($urandom_range(0, 5))
        0: begin
          lo_p = '0;
          hi_p = '1;
        end
        1: begin
          lo_p = PULSE_W'($urandom_range(2048, 4095));
          hi_p = PULSE_W'($urandom_range(0, 2047));
        end
        default: begin
          lo_p = PULSE_W'($urandom_range(0, 2000));
          hi_p = PULSE_W'($urandom_range(2000, 4095));
        end
      endcase
      inv = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: w = '0;
        1: w = '1;
        default: w = WEIGHT_W'($urandom_range(1, 16));
      endcase
      if ($urandom_range(0, 3) == 0) en = '1;
      else en = EN_W'($urandom | $urandom) | (EN_W'(1) << $urandom_range(0, 15));
    end
    write_register(REG_INPUT_LOW, pad_upper(CFG_DATA_W'(lo_in), SAMPLE_W), 1'b1);
    write_register(REG_INPUT_HIGH, pad_upper(CFG_DATA_W'(hi_in), SAMPLE_W), 1'b1);
    write_register(REG_PULSE_LOW, pad_upper(CFG_DATA_W'(lo_p), PULSE_W), 1'b1);
    write_register(REG_PULSE_HIGH, pad_upper(CFG_DATA_W'(hi_p), PULSE_W), 1'b1);
    write_register(REG_INVERT_DIR, pad_upper(CFG_DATA_W'(inv), 1), 1'b1);
    write_register(REG_SMOOTH_WEIGHT, pad_upper(CFG_DATA_W'(w), WEIGHT_W), 1'b1);
    write_register(REG_CHANNEL_ENABLE, en, 1'b0);
  endtask

  // Result pacing: pop held low for random stretches.
  always @(posedge clk) begin
    if (pop_hold != 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      pop_hold <= gap_length();
    end
  end

  // Watch all three channels: predict on each command transfer, check each result transfer.
  always @(posedge clk) begin : track
    pulse_update_t want;
    pulse_update_t predicted;
    servo_cmd_t taken;
    logic busy;
    if (!rst_n) begin
      tracked_cfg.input_low = RST_INPUT_LOW;
      tracked_cfg.input_high = RST_INPUT_HIGH;
      tracked_cfg.pulse_low = RST_PULSE_LOW;
      tracked_cfg.pulse_high = RST_PULSE_HIGH;
      tracked_cfg.invert_dir = 1'b0;
      tracked_cfg.smooth_weight = '0;
      tracked_cfg.channel_enable = '0;
      foreach (smoothed_pos[i]) smoothed_pos[i] = '0;
      quiet_cycles = 0;
    end else begin
      busy = 1'b0;
      // Result transfer: compare against the oldest expectation.
      if (out_pop && !out_empty) begin
        busy = 1'b1;
        if (pending_updates.size() == 0) begin
          report_mismatch("result with none pending on channel", out_channel, -1);
        end else begin
          want = pending_updates.pop_front();
          if (out_channel !== want.ch)
            report_mismatch("out_channel", out_channel, want.ch);
          if (out_pulse_width !== want.pulse)
            report_mismatch("out_pulse_width", out_pulse_width, want.pulse);
          if (out_recorded_byte !== want.rec_byte)
            report_mismatch("out_recorded_byte", out_recorded_byte, want.rec_byte);
          if (out_record_valid !== want.rec_valid)
            report_mismatch("out_record_valid", out_record_valid, want.rec_valid);
          updates_checked++;
          if (want.rec_valid) records_checked++;
        end
      end
      // Command transfer: run the predictor, or take the typed-in value.
      if (in_push && !in_full) begin
        busy = 1'b1;
        items_sent++;
        taken = '{op: in_operation, ch: in_channel, sample: in_sample};
        if (predict_pulse_update(taken, predicted)) begin
          if (pinned_on) predicted = pinned_update;
          pending_updates.push_back(predicted);
        end else begin
          items_ignored++;
        end
      end
      // Register transfer.
      if (cfg_valid && cfg_ready) begin
        busy = 1'b1;
        reg_writes++;
        case (cfg_index)
          REG_INPUT_LOW:      tracked_cfg.input_low = cfg_data[SAMPLE_W-1:0];
          REG_INPUT_HIGH:     tracked_cfg.input_high = cfg_data[SAMPLE_W-1:0];
          REG_PULSE_LOW:      tracked_cfg.pulse_low = cfg_data[PULSE_W-1:0];
          REG_PULSE_HIGH:     tracked_cfg.pulse_high = cfg_data[PULSE_W-1:0];
          REG_INVERT_DIR:     tracked_cfg.invert_dir = cfg_data[0];
          REG_SMOOTH_WEIGHT:  tracked_cfg.smooth_weight = cfg_data[WEIGHT_W-1:0];
          REG_CHANNEL_ENABLE: tracked_cfg.channel_enable = cfg_data[EN_W-1:0];
          default: ;
        endcase
      end
      // Watchdog on cycles with no transfer anywhere.
      if (busy) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t row;
    servo_cmd_t c;
    logic next_is_cfg;
    logic prev_was_cfg;
    int phase_items;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    directed_plan = '{
      // All channels are off after reset, so this one is dropped.
      cmd_row(OP_LIVE, 4'd0, 10'd1023),
      reg_row(REG_CHANNEL_ENABLE, 16'h7FFF),
      // Default ranges: reading and stored-byte extremes land on the pulse ends.
      known_row(OP_LIVE, 4'd0, 10'd0, 12'd150, 8'd0, 1'b0),
      known_row(OP_LIVE, 4'd1, 10'd1023, 12'd600, 8'd0, 1'b0),
      known_row(OP_RECORD, 4'd2, 10'd1023, 12'd600, 8'd255, 1'b1),
      known_row(OP_RECORD, 4'd3, 10'd0, 12'd150, 8'd0, 1'b1),
      known_row(OP_PLAY, 4'd4, 10'd255, 12'd600, 8'd0, 1'b0),
      // A stored byte above 255 saturates.
      known_row(OP_PLAY, 4'd5, 10'd1023, 12'd600, 8'd0, 1'b0),
      known_row(OP_PLAY, 4'd6, 10'd0, 12'd150, 8'd0, 1'b0),
      // Unused operation and a disabled channel are both dropped.
      cmd_row(OP_UNUSED, 4'd0, 10'd512),
      cmd_row(OP_LIVE, 4'd15, 10'd512),
      cmd_row(OP_LIVE, 4'd7, 10'd512),
      cmd_row(OP_RECORD, 4'd8, 10'd341),
      // Equal input bounds, full inverted pulse range, heaviest smoothing.
      reg_row(REG_INPUT_LOW, 16'hFC64),
      reg_row(REG_INPUT_HIGH, 16'h0064),
      reg_row(REG_PULSE_LOW, 16'hFFFF),
      reg_row(REG_PULSE_HIGH, 16'h0000),
      reg_row(REG_INVERT_DIR, 16'h0001),
      reg_row(REG_SMOOTH_WEIGHT, 16'hA5FF),
      reg_row(REG_UNUSED, 16'h5A5A),
      reg_row(REG_CHANNEL_ENABLE, 16'hFFFF),
      known_row(OP_LIVE, 4'd0, 10'd50, 12'd0, 8'd0, 1'b0),
      cmd_row(OP_RECORD, 4'd1, 10'd1023),
      cmd_row(OP_PLAY, 4'd2, 10'd255),
      // Live read of a pulse-domain state drives the pulse into saturation.
      cmd_row(OP_LIVE, 4'd2, 10'd0),
      // Reversed input bounds: readings below the lower bound clamp to it and map to zero.
      reg_row(REG_INPUT_LOW, 16'h03FF),
      reg_row(REG_INPUT_HIGH, 16'h0000),
      reg_row(REG_SMOOTH_WEIGHT, 16'h0000),
      known_row(OP_LIVE, 4'd3, 10'd500, 12'd0, 8'd0, 1'b0),
      known_row(OP_RECORD, 4'd4, 10'd0, 12'd0, 8'd0, 1'b1)
    };

    // Directed table.
    prev_was_cfg = 1'b0;
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      next_is_cfg = (i + 1 < DIRECTED_ROWS) && directed_plan[i + 1].is_cfg;
      if (row.is_cfg) begin
        if (!prev_was_cfg) wait_idle();
        write_register(row.idx, row.data, next_is_cfg);
      end else begin
        send_command(row.cmd, row.pinned, row.want);
      end
      prev_was_cfg = row.is_cfg;
    end

    // Random phases, each under fresh settings; every command sent counts, dropped or not.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      program_phase(phase);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        c = random_command();
        phase_items++;
        send_command(c, 1'b0, '0);
      end
    end

    wait_idle();
    $display("tb: %0d commands sent, %0d dropped, %0d pulse updates checked, %0d with a byte",
             items_sent, items_ignored, updates_checked, records_checked);
    $display("tb: %0d register writes over the directed table and %0d random phases",
             reg_writes, RANDOM_PHASES);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
